// ===== hw/rtl/ill_pkg.sv =====
`timescale 1ns / 1ps

package ill_pkg;

  localparam int OP_W    = 2;
  localparam int POS_W   = 8;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 3;
  localparam int FOUND_W = 8;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_FRESH,
    S_WALK,
    S_PREV,
    S_VICTIM,
    S_RELINK,
    S_SEARCH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic val_we;
  } store_ctrl_t;

endpackage

// ===== hw/rtl/indexed_linked_list_engine.sv =====
`timescale 1ns / 1ps

// Linked list of up to DEPTH signed 32-bit elements with a free list, both
// chained through one link memory beside a value memory; each beat is an
// insert, delete or search (other op codes are rejected as a bad position)
// and returns one status beat. After reset the block stalls its input while
// it chains every node into the free list. One item is worked at a time,
// bounded by the registered read port walking the chain one node per cycle.
// A finished result waits in the output register while the next beat is
// taken.
module indexed_linked_list_engine #(
  parameter int DEPTH = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ill_pkg::OP_W-1:0]            in_op,
  input  logic [ill_pkg::POS_W-1:0]           in_position,
  input  logic signed [ill_pkg::VAL_W-1:0]    in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ill_pkg::STAT_W-1:0]          out_status,
  output logic [ill_pkg::FOUND_W-1:0]         out_found_position
);
  import ill_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam logic [LW-1:0] NIL = LW'(DEPTH);

  state_t state_r, state_nxt;

  logic [AW-1:0]      init_idx_r, init_idx_nxt;
  logic [LW-1:0]      list_head_r, list_head_nxt;
  logic [LW-1:0]      free_head_r, free_head_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [POS_W-1:0]   left_r, left_nxt;
  logic [LW-1:0]      prev_r, prev_nxt;
  logic [LW-1:0]      victim_r, victim_nxt;
  logic [LW-1:0]      fresh_link_r, fresh_link_nxt;
  logic [FOUND_W-1:0] cnt_r, cnt_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic [FOUND_W-1:0] found_r, found_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [FOUND_W-1:0] out_found_r, out_found_nxt;

  store_ctrl_t        ctrl;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      link_waddr;
  logic [LW-1:0]      link_wdata;
  logic [AW-1:0]      val_waddr;
  logic [VAL_W-1:0]   val_wdata;
  logic [LW-1:0]      rd_link;
  logic [VAL_W-1:0]   rd_val;

  logic               in_fire;
  logic               out_load;
  logic               init_last;
  logic [LW-1:0]      walk_node;
  logic [POS_W-1:0]   walk_base;
  logic [POS_W-1:0]   walk_left;
  logic               walk_nil;
  logic               walk_end;
  logic               match;
  state_t             walk_goto;

  ill_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk        (clk),
    .ctrl       (ctrl),
    .rd_addr    (rd_addr),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .val_waddr  (val_waddr),
    .val_wdata  (val_wdata),
    .rd_link    (rd_link),
    .rd_val     (rd_val)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign in_fire    = in_valid && !in_stall;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign init_last  = (init_idx_r == AW'(DEPTH - 1));
  assign match      = (rd_val == val_r);

  assign walk_node  = (state_r == S_WALK) ? rd_link : list_head_r;
  assign walk_base  = (state_r == S_IDLE) ? in_position : pos_r;
  assign walk_left  = (state_r == S_WALK) ? (left_r - POS_W'(1)) : (walk_base - POS_W'(2));
  assign walk_nil   = (walk_node == NIL);
  assign walk_end   = (walk_left == '0) || walk_nil;
  assign walk_goto  = walk_end ? (walk_nil ? S_DONE : S_PREV) : S_WALK;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_INSERT: begin
              if (free_head_r == NIL || in_position == '0) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_FRESH;
              end
            end
            OP_DELETE: begin
              if (list_head_r == NIL || in_position == '0) begin
                state_nxt = S_DONE;
              end else if (in_position == POS_W'(1)) begin
                state_nxt = S_VICTIM;
              end else begin
                state_nxt = walk_goto;
              end
            end
            OP_SEARCH: begin
              state_nxt = (list_head_r == NIL) ? S_DONE : S_SEARCH;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_FRESH: begin
        state_nxt = (pos_r == POS_W'(1)) ? S_DONE : walk_goto;
      end
      S_WALK: begin
        state_nxt = walk_goto;
      end
      S_PREV: begin
        if (op_r == OP_INSERT) begin
          state_nxt = S_RELINK;
        end else begin
          state_nxt = (rd_link == NIL) ? S_DONE : S_VICTIM;
        end
      end
      S_VICTIM: begin
        state_nxt = S_RELINK;
      end
      S_RELINK: begin
        state_nxt = S_DONE;
      end
      S_SEARCH: begin
        state_nxt = (match || rd_link == NIL) ? S_DONE : S_SEARCH;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // memory control and datapath
  always_comb begin
    ctrl           = '0;
    rd_addr        = '0;
    link_waddr     = '0;
    link_wdata     = '0;
    val_waddr      = free_head_r[AW-1:0];
    val_wdata      = val_r;
    init_idx_nxt   = init_idx_r;
    list_head_nxt  = list_head_r;
    free_head_nxt  = free_head_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    left_nxt       = left_r;
    prev_nxt       = prev_r;
    victim_nxt     = victim_r;
    fresh_link_nxt = fresh_link_r;
    cnt_nxt        = cnt_r;
    status_nxt     = status_r;
    found_nxt      = found_r;

    case (state_r)
      S_INIT: begin
        ctrl.link_we = 1'b1;
        link_waddr   = init_idx_r;
        link_wdata   = LW'(init_idx_r) + LW'(1);
        init_idx_nxt = init_idx_r + AW'(1);
      end
      S_IDLE: begin
        if (in_fire) begin
          op_nxt     = in_op;
          pos_nxt    = in_position;
          val_nxt    = in_value;
          found_nxt  = '0;
          status_nxt = ST_OK;
          case (in_op)
            OP_INSERT: begin
              if (free_head_r == NIL) begin
                status_nxt = ST_FULL;
              end else if (in_position == '0) begin
                status_nxt = ST_BADPOS;
              end else begin
                ctrl.rd_en = 1'b1;
                rd_addr    = free_head_r[AW-1:0];
              end
            end
            OP_DELETE: begin
              if (list_head_r == NIL) begin
                status_nxt = ST_EMPTY;
              end else if (in_position == '0) begin
                status_nxt = ST_BADPOS;
              end else if (in_position == POS_W'(1)) begin
                ctrl.rd_en = 1'b1;
                rd_addr    = list_head_r[AW-1:0];
                victim_nxt = list_head_r;
              end else if (walk_end && walk_nil) begin
                status_nxt = ST_BADPOS;
              end else begin
                ctrl.rd_en = 1'b1;
                rd_addr    = walk_node[AW-1:0];
                prev_nxt   = walk_node;
                left_nxt   = walk_left;
              end
            end
            OP_SEARCH: begin
              if (list_head_r == NIL) begin
                status_nxt = ST_NOTFOUND;
              end else begin
                ctrl.rd_en = 1'b1;
                rd_addr    = list_head_r[AW-1:0];
                cnt_nxt    = FOUND_W'(1);
              end
            end
            default: begin
              status_nxt = ST_BADPOS;
            end
          endcase
        end
      end
      S_FRESH: begin
        fresh_link_nxt = rd_link;
        if (pos_r == POS_W'(1)) begin
          ctrl.link_we  = 1'b1;
          ctrl.val_we   = 1'b1;
          link_waddr    = free_head_r[AW-1:0];
          link_wdata    = list_head_r;
          list_head_nxt = free_head_r;
          free_head_nxt = rd_link;
        end else if (walk_end && walk_nil) begin
          status_nxt = ST_BADPOS;
        end else begin
          ctrl.rd_en = 1'b1;
          rd_addr    = walk_node[AW-1:0];
          prev_nxt   = walk_node;
          left_nxt   = walk_left;
        end
      end
      S_WALK: begin
        if (walk_end && walk_nil) begin
          status_nxt = ST_BADPOS;
        end else begin
          ctrl.rd_en = 1'b1;
          rd_addr    = walk_node[AW-1:0];
          prev_nxt   = walk_node;
          left_nxt   = walk_left;
        end
      end
      S_PREV: begin
        if (op_r == OP_INSERT) begin
          ctrl.link_we = 1'b1;
          ctrl.val_we  = 1'b1;
          link_waddr   = free_head_r[AW-1:0];
          link_wdata   = rd_link;
        end else if (rd_link == NIL) begin
          status_nxt = ST_BADPOS;
        end else begin
          ctrl.rd_en = 1'b1;
          rd_addr    = rd_link[AW-1:0];
          victim_nxt = rd_link;
        end
      end
      S_VICTIM: begin
        if (pos_r == POS_W'(1)) begin
          list_head_nxt = rd_link;
        end else begin
          ctrl.link_we = 1'b1;
          link_waddr   = prev_r[AW-1:0];
          link_wdata   = rd_link;
        end
      end
      S_RELINK: begin
        ctrl.link_we = 1'b1;
        if (op_r == OP_INSERT) begin
          link_waddr    = prev_r[AW-1:0];
          link_wdata    = free_head_r;
          free_head_nxt = fresh_link_r;
        end else begin
          link_waddr    = victim_r[AW-1:0];
          link_wdata    = free_head_r;
          free_head_nxt = victim_r;
        end
      end
      S_SEARCH: begin
        if (match) begin
          found_nxt = cnt_r;
        end else if (rd_link == NIL) begin
          status_nxt = ST_NOTFOUND;
        end else begin
          ctrl.rd_en = 1'b1;
          rd_addr    = rd_link[AW-1:0];
          cnt_nxt    = cnt_r + FOUND_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      out_found_nxt  = found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_idx_r  <= '0;
      list_head_r <= NIL;
      free_head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_idx_r  <= init_idx_nxt;
      list_head_r <= list_head_nxt;
      free_head_r <= free_head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    left_r       <= left_nxt;
    prev_r       <= prev_nxt;
    victim_r     <= victim_nxt;
    fresh_link_r <= fresh_link_nxt;
    cnt_r        <= cnt_nxt;
    status_r     <= status_nxt;
    found_r      <= found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;

endmodule

// ===== hw/rtl/ill_store.sv =====
`timescale 1ns / 1ps

module ill_store #(
  parameter int DEPTH = 128
) (
  input  logic                                clk,
  input  ill_pkg::store_ctrl_t                ctrl,
  input  logic [$clog2(DEPTH)-1:0]            rd_addr,
  input  logic [$clog2(DEPTH)-1:0]            link_waddr,
  input  logic [$clog2(DEPTH+1)-1:0]          link_wdata,
  input  logic [$clog2(DEPTH)-1:0]            val_waddr,
  input  logic [ill_pkg::VAL_W-1:0]           val_wdata,
  output logic [$clog2(DEPTH+1)-1:0]          rd_link,
  output logic [ill_pkg::VAL_W-1:0]           rd_val
);
  import ill_pkg::*;

  localparam int LW = $clog2(DEPTH + 1);

  logic [LW-1:0]    link_mem [DEPTH];
  logic [VAL_W-1:0] val_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (ctrl.rd_en) begin
      rd_link <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    if (ctrl.rd_en) begin
      rd_val <= val_mem[rd_addr];
    end
  end

endmodule
